// ===== hdl/clt_pkg.sv =====
// shared types, codes and constants of the connect latency tracker
package clt_pkg;

	localparam int unsigned PEND_DEPTH_DEF = 4096;
	localparam int unsigned HOST_DEPTH_DEF = 1024;
	localparam int unsigned LIMIT_W = 40;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 40'd30000000000;
	localparam logic [7:0] MIN_ADDR_LEN = 8'd8;
	localparam logic [15:0] FAMILY_IPV4 = 16'd2;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_FINISH = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NOT_IPV4     = 3'd1,
		ST_PENDING_FULL = 3'd2,
		ST_NO_PENDING   = 3'd3,
		ST_HOST_FULL    = 3'd4,
		ST_HOST_ABSENT  = 3'd5
	} stat_t;

	// slot life cycle: never used, holding a key, freed
	typedef enum logic [1:0] {
		SL_EMPTY = 2'd0,
		SL_USED  = 2'd1,
		SL_DEAD  = 2'd2
	} slot_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PSCAN,
		S_HSCAN,
		S_CALC,
		S_ADD,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic [63:0] start_time;
		logic [47:0] dest;
		logic [63:0] thread;
		slot_t       st;
	} pend_ent_t;

	typedef struct packed {
		logic [63:0] lat_cnt;
		logic [63:0] lat_sum;
		logic [63:0] fails;
		logic [63:0] connects;
		logic [47:0] dest;
		slot_t       st;
	} host_ent_t;

	typedef struct packed {
		logic done;
		logic found;
		logic avail;
	} scan_res_t;

endpackage

// ===== hdl/clt_ram.sv =====
// generic single write port ram with registered read
module clt_ram #(
	parameter int unsigned W = 8,
	parameter int unsigned D = 2
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/clt_scan.sv =====
// linear probe over a table memory: finds a key or the first free slot
module clt_scan #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned KW = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [KW-1:0]            key,
	input  logic [1:0]               rd_state,
	input  logic [KW-1:0]            rd_key,
	output logic [$clog2(DEPTH)-1:0] raddr,
	output clt_pkg::scan_res_t       res,
	output logic [$clog2(DEPTH)-1:0] idx
);
	import clt_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic          busy_q;
	logic          iss_q;
	logic [AW-1:0] addr_q;
	logic          chk_s1;
	logic [AW-1:0] addr_s1;
	logic [KW-1:0] key_q;
	logic          free_q;
	logic [AW-1:0] fidx_q;
	scan_res_t     res_q;
	logic [AW-1:0] idx_q;

	logic hit;
	logic empty;
	logic dead;
	logic last;
	logic stop;

	assign hit   = chk_s1 && (rd_state == SL_USED) && (rd_key == key_q);
	assign empty = chk_s1 && (rd_state == SL_EMPTY);
	assign dead  = chk_s1 && (rd_state == SL_DEAD);
	assign last  = chk_s1 && (addr_s1 == LAST);
	assign stop  = hit || empty || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			iss_q  <= 1'b0;
			chk_s1 <= 1'b0;
			free_q <= 1'b0;
			res_q  <= '0;
		end else begin
			res_q.done <= busy_q && !start && stop;
			if (start) begin
				busy_q <= 1'b1;
				iss_q  <= 1'b1;
				chk_s1 <= 1'b0;
				free_q <= 1'b0;
			end else if (busy_q) begin
				chk_s1 <= iss_q && !stop;
				if ((iss_q && addr_q == LAST) || stop) begin
					iss_q <= 1'b0;
				end
				if (dead && !free_q) begin
					free_q <= 1'b1;
				end
				if (stop) begin
					busy_q      <= 1'b0;
					res_q.found <= hit;
					res_q.avail <= !hit && (free_q || dead || empty);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			addr_q <= '0;
			key_q  <= key;
		end else if (busy_q) begin
			addr_s1 <= addr_q;
			if (iss_q && addr_q != LAST) begin
				addr_q <= addr_q + 1'b1;
			end
			if (dead && !free_q) begin
				fidx_q <= addr_s1;
			end
			if (stop) begin
				idx_q <= (hit || !free_q) ? addr_s1 : fidx_q;
			end
		end
	end

	assign raddr = addr_q;
	assign res   = res_q;
	assign idx   = idx_q;

endmodule

// ===== hdl/connect_latency_tracker.sv =====
// connect latency tracker: pending and host tables in ram, probed by a sequencer
// probing: start/finish probe the pending table, one slot a cycle, up to a key hit,
//   the first never-used slot or the last slot; a finish that finds its thread
//   then probes the host table; a query probes only the host table
// throughput: one item at a time; the next is taken once the result is registered
// reset: a sweep over every address of both tables marks every slot empty
//   before the first item is accepted; the limit register resets to 30 s
module connect_latency_tracker #(
	parameter int unsigned PENDING_DEPTH = clt_pkg::PEND_DEPTH_DEF,
	parameter int unsigned HOST_DEPTH    = clt_pkg::HOST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [63:0] thread_id,
	input  logic [63:0] now_ns,
	input  logic        addr_readable,
	input  logic [7:0]  addr_len,
	input  logic [15:0] addr_family,
	input  logic [31:0] dest_addr,
	input  logic [15:0] dest_port,
	input  logic        call_failed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] hit_count,
	output logic [63:0] host_connects,
	output logic [63:0] host_fails,
	output logic [63:0] host_latency_sum,
	output logic [63:0] host_latency_count,
	output logic        latency_taken
);
	import clt_pkg::*;

	localparam int unsigned PAW  = $clog2(PENDING_DEPTH);
	localparam int unsigned HAW  = $clog2(HOST_DEPTH);
	localparam int unsigned MAXD =
		(PENDING_DEPTH > HOST_DEPTH) ? PENDING_DEPTH : HOST_DEPTH;
	localparam int unsigned CW   = $clog2(MAXD);

	fsm_t             state_q, state_d;
	logic [CW-1:0]    clr_q;
	logic [63:0]      hits_q;
	logic [LIMIT_W-1:0] limit_q;
	logic             out_valid_q;

	op_t              op_q;
	logic [63:0]      tid_q;
	logic [63:0]      now_q;
	logic [47:0]      key_q;
	logic             fail_q;
	logic [63:0]      t0_q;
	logic [63:0]      diff_q;
	logic             ok_q;
	stat_t            st_q;
	logic [63:0]      c0_q, c1_q, c2_q, c3_q;
	logic             taken_q;
	pend_ent_t        phold_q;
	host_ent_t        hhold_q;

	stat_t            o_st_q;
	logic [63:0]      o_hits_q, o_c0_q, o_c1_q, o_c2_q, o_c3_q;
	logic             o_taken_q;

	logic             accept;
	logic             ipv4;
	logic [47:0]      key_in;
	logic             cfg_wr;
	logic             out_load;
	logic             clr_p, clr_h;

	logic             p_start, h_start;
	logic [47:0]      h_key;
	logic             p_we, h_we;
	logic [PAW-1:0]   p_waddr, p_raddr, pidx;
	logic [HAW-1:0]   h_waddr, h_raddr, hidx;
	pend_ent_t        p_wdata, prd;
	host_ent_t        h_wdata, hrd, hnew;
	scan_res_t        pres, hres;
	logic [63:0]      diff;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && !paddr[3];
	assign prdata   = paddr[3] ? 64'd0 : {{(64 - LIMIT_W){1'b0}}, limit_q};
	assign ipv4     = addr_readable && (addr_len >= MIN_ADDR_LEN) &&
		(addr_family == FAMILY_IPV4);
	assign key_in   = {dest_addr, dest_port};
	assign accept   = in_valid && in_ready;
	assign out_load = !out_valid_q || out_ready;
	assign clr_p    = {1'b0, clr_q} < (CW + 1)'(PENDING_DEPTH);
	assign clr_h    = {1'b0, clr_q} < (CW + 1)'(HOST_DEPTH);
	assign diff     = now_q - t0_q;

	clt_ram #(.W($bits(pend_ent_t)), .D(PENDING_DEPTH)) u_pend_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (prd)
	);

	clt_ram #(.W($bits(host_ent_t)), .D(HOST_DEPTH)) u_host_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (hrd)
	);

	clt_scan #(.DEPTH(PENDING_DEPTH), .KW(64)) u_pend_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (p_start),
		.key      (thread_id),
		.rd_state (prd.st),
		.rd_key   (prd.thread),
		.raddr    (p_raddr),
		.res      (pres),
		.idx      (pidx)
	);

	clt_scan #(.DEPTH(HOST_DEPTH), .KW(48)) u_host_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (h_start),
		.key      (h_key),
		.rd_state (hrd.st),
		.rd_key   (hrd.dest),
		.raddr    (h_raddr),
		.res      (hres),
		.idx      (hidx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == CW'(MAXD - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(opcode))
						OP_START:  state_d = ipv4 ? S_PSCAN : S_OUT;
						OP_FINISH: state_d = S_PSCAN;
						OP_QUERY:  state_d = S_HSCAN;
						OP_NONE:   state_d = S_OUT;
					endcase
				end
			end
			S_PSCAN: begin
				if (pres.done) state_d = (op_q == OP_FINISH && pres.found) ? S_HSCAN : S_OUT;
			end
			S_HSCAN: begin
				if (hres.done) begin
					state_d = (op_q == OP_FINISH && (hres.found || hres.avail)) ? S_CALC : S_OUT;
				end
			end
			S_CALC: state_d = S_ADD;
			S_ADD:  state_d = S_OUT;
			S_OUT: begin
				if (out_load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		hnew          = hhold_q;
		hnew.st       = SL_USED;
		hnew.dest     = key_q;
		hnew.connects = c0_q + 64'd1;
		hnew.fails    = c1_q + {63'd0, fail_q};
		hnew.lat_sum  = ok_q ? c2_q + diff_q : c2_q;
		hnew.lat_cnt  = ok_q ? c3_q + 64'd1 : c3_q;
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = (state_q == S_IDLE);
		p_start  = 1'b0;
		h_start  = 1'b0;
		h_key    = phold_q.dest;
		p_we     = 1'b0;
		p_waddr  = pidx;
		p_wdata  = phold_q;
		h_we     = 1'b0;
		h_waddr  = hidx;
		h_wdata  = hnew;
		unique case (state_q)
			S_CLEAR: begin
				p_we    = clr_p;
				p_waddr = clr_q[PAW-1:0];
				p_wdata = '0;
				h_we    = clr_h;
				h_waddr = clr_q[HAW-1:0];
				h_wdata = '0;
			end
			S_IDLE: begin
				h_key   = key_in;
				p_start = accept && ((op_t'(opcode) == OP_START && ipv4) ||
					op_t'(opcode) == OP_FINISH);
				h_start = accept && (op_t'(opcode) == OP_QUERY);
			end
			S_PSCAN: begin
				if (pres.done) begin
					if (op_q == OP_START) begin
						p_we    = pres.found || pres.avail;
						p_wdata = '{start_time: now_q, dest: key_q, thread: tid_q, st: SL_USED};
					end else begin
						p_we       = pres.found;
						p_wdata.st = SL_DEAD;
						h_start    = pres.found;
					end
				end
			end
			S_ADD: h_we = 1'b1;
			S_HSCAN, S_CALC, S_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			hits_q      <= '0;
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg_wr) limit_q <= pwdata[LIMIT_W-1:0];
			if (accept && op_t'(opcode) == OP_START) hits_q <= hits_q + 64'd1;
			if (state_q == S_OUT && out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q    <= op_t'(opcode);
					tid_q   <= thread_id;
					now_q   <= now_ns;
					key_q   <= key_in;
					fail_q  <= call_failed;
					st_q    <= (op_t'(opcode) == OP_START && !ipv4) ? ST_NOT_IPV4 : ST_OK;
					c0_q    <= '0;
					c1_q    <= '0;
					c2_q    <= '0;
					c3_q    <= '0;
					taken_q <= 1'b0;
					ok_q    <= 1'b0;
				end
			end
			S_PSCAN: begin
				if (!pres.done) begin
					phold_q <= prd;
				end else if (op_q == OP_START) begin
					if (!(pres.found || pres.avail)) st_q <= ST_PENDING_FULL;
				end else if (!pres.found) begin
					st_q <= ST_NO_PENDING;
				end else begin
					t0_q  <= phold_q.start_time;
					key_q <= phold_q.dest;
				end
			end
			S_HSCAN: begin
				if (!hres.done) begin
					hhold_q <= hrd;
				end else if (hres.found) begin
					c0_q <= hhold_q.connects;
					c1_q <= hhold_q.fails;
					c2_q <= hhold_q.lat_sum;
					c3_q <= hhold_q.lat_cnt;
				end else if (op_q == OP_QUERY) begin
					st_q <= ST_HOST_ABSENT;
				end else if (!hres.avail) begin
					st_q <= ST_HOST_FULL;
				end
			end
			S_CALC: begin
				diff_q <= diff;
				ok_q   <= (now_q > t0_q) && (diff < {{(64 - LIMIT_W){1'b0}}, limit_q});
			end
			S_ADD: begin
				c0_q    <= hnew.connects;
				c1_q    <= hnew.fails;
				c2_q    <= hnew.lat_sum;
				c3_q    <= hnew.lat_cnt;
				taken_q <= ok_q;
			end
			S_OUT: begin
				if (out_load) begin
					o_st_q    <= st_q;
					o_hits_q  <= hits_q;
					o_c0_q    <= c0_q;
					o_c1_q    <= c1_q;
					o_c2_q    <= c2_q;
					o_c3_q    <= c3_q;
					o_taken_q <= taken_q;
				end
			end
			S_CLEAR: ;
			default: ;
		endcase
	end

	assign out_valid          = out_valid_q;
	assign status             = o_st_q;
	assign hit_count          = o_hits_q;
	assign host_connects      = o_c0_q;
	assign host_fails         = o_c1_q;
	assign host_latency_sum   = o_c2_q;
	assign host_latency_count = o_c3_q;
	assign latency_taken      = o_taken_q;

	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		hres.done |-> !(hres.found && hres.avail))
		else $error("host probe reports both hit and free slot");

	a_start_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PSCAN && pres.done && op_q == OP_START) |->
		(p_we == (pres.found || pres.avail)))
		else $error("start record written without a slot");

	a_taken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && latency_taken) |-> (status == ST_OK))
		else $error("latency sample with failing status");

	a_add_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |=> (state_q == S_OUT))
		else $error("host update not followed by result");

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the connect latency tracker: directed and random runs
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import clt_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 20000000;
	localparam int unsigned RAND_PHASE  = 262;
	localparam int unsigned TID_POOL    = 24;
	localparam int unsigned KEY_POOL    = 16;

	typedef struct {
		op_t         op;
		logic [63:0] tid;
		logic [63:0] now;
		logic        readable;
		logic [7:0]  alen;
		logic [15:0] fam;
		logic [31:0] daddr;
		logic [15:0] dport;
		logic        failed;
	} conn_evt_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] hits;
		logic [63:0] connects;
		logic [63:0] fails;
		logic [63:0] lat_sum;
		logic [63:0] lat_cnt;
		logic        taken;
	} host_stats_t;

	typedef struct {
		logic [47:0] dest;
		logic [63:0] t0;
	} open_conn_t;

	typedef struct {
		logic [63:0] connects;
		logic [63:0] fails;
		logic [63:0] lat_sum;
		logic [63:0] lat_cnt;
	} host_ctr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic in_valid = 1'b0, in_ready;
	logic [1:0] opcode = '0;
	logic [63:0] thread_id = '0, now_ns = '0;
	logic addr_readable = 1'b0;
	logic [7:0] addr_len = '0;
	logic [15:0] addr_family = '0;
	logic [31:0] dest_addr = '0;
	logic [15:0] dest_port = '0;
	logic call_failed = 1'b0;
	logic out_valid, out_ready = 1'b0;
	logic [2:0] status;
	logic [63:0] hit_count, host_connects, host_fails, host_latency_sum, host_latency_count;
	logic latency_taken;

	conn_evt_t   evt_queue[$];
	host_stats_t stats_due[$];
	open_conn_t  open_conns[logic [63:0]];
	host_ctr_t   host_ctrs[logic [47:0]];
	logic [39:0] limit_ns = LIMIT_RESET;
	logic [63:0] start_hits = '0;
	logic [63:0] tid_pool[TID_POOL];
	logic [47:0] key_pool[KEY_POOL];
	logic [63:0] sim_clock = 64'd1000;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned long_hold_req = 0;
	bit no_gaps = 1'b0;
	logic in_fire = 1'b0, out_fire = 1'b0;
	int unsigned in_gap = 0, out_gap = 0, long_hold = 0;

	connect_latency_tracker i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .thread_id(thread_id), .now_ns(now_ns),
		.addr_readable(addr_readable), .addr_len(addr_len), .addr_family(addr_family),
		.dest_addr(dest_addr), .dest_port(dest_port), .call_failed(call_failed),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .hit_count(hit_count), .host_connects(host_connects),
		.host_fails(host_fails), .host_latency_sum(host_latency_sum),
		.host_latency_count(host_latency_count), .latency_taken(latency_taken)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic track_connect();
		host_stats_t r;
		logic [47:0] key;
		open_conn_t oc;
		host_ctr_t hc;
		r = '0;
		r.status = ST_OK;
		key = {dest_addr, dest_port};
		case (op_t'(opcode))
			OP_START: begin
				start_hits++;
				if (!addr_readable || addr_len < MIN_ADDR_LEN || addr_family != FAMILY_IPV4)
					r.status = ST_NOT_IPV4;
				else if (!open_conns.exists(thread_id) && open_conns.num() >= PEND_DEPTH_DEF)
					r.status = ST_PENDING_FULL;
				else begin
					oc.dest = key;
					oc.t0 = now_ns;
					open_conns[thread_id] = oc;
				end
			end
			OP_FINISH: begin
				if (!open_conns.exists(thread_id))
					r.status = ST_NO_PENDING;
				else begin
					oc = open_conns[thread_id];
					if (!host_ctrs.exists(oc.dest) && host_ctrs.num() >= HOST_DEPTH_DEF)
						r.status = ST_HOST_FULL;
					else begin
						if (host_ctrs.exists(oc.dest))
							hc = host_ctrs[oc.dest];
						else
							hc = '{default: '0};
						hc.connects++;
						if (call_failed)
							hc.fails++;
						if (now_ns > oc.t0 && now_ns - oc.t0 < {24'd0, limit_ns}) begin
							hc.lat_sum += now_ns - oc.t0;
							hc.lat_cnt++;
							r.taken = 1'b1;
						end
						host_ctrs[oc.dest] = hc;
						r.connects = hc.connects;
						r.fails = hc.fails;
						r.lat_sum = hc.lat_sum;
						r.lat_cnt = hc.lat_cnt;
					end
					open_conns.delete(thread_id);
				end
			end
			OP_QUERY: begin
				if (host_ctrs.exists(key)) begin
					hc = host_ctrs[key];
					r.connects = hc.connects;
					r.fails = hc.fails;
					r.lat_sum = hc.lat_sum;
					r.lat_cnt = hc.lat_cnt;
				end else
					r.status = ST_HOST_ABSENT;
			end
			default: ;
		endcase
		r.hits = start_hits;
		stats_due.push_back(r);
	endtask

	// driver
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready)
			track_connect();
	end

	always @(negedge clk) begin
		conn_evt_t e;
		if (!in_valid || in_fire) begin
			if (in_gap > 0 || evt_queue.size() == 0) begin
				in_valid <= 1'b0;
				if (in_gap > 0)
					in_gap--;
			end else begin
				e = evt_queue.pop_front();
				in_valid <= 1'b1;
				opcode <= e.op;
				thread_id <= e.tid;
				now_ns <= e.now;
				addr_readable <= e.readable;
				addr_len <= e.alen;
				addr_family <= e.fam;
				dest_addr <= e.daddr;
				dest_port <= e.dport;
				call_failed <= e.failed;
				in_gap = no_gaps ? 0 : $urandom_range(0, 4);
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (long_hold_req != 0) begin
			long_hold = long_hold_req;
			long_hold_req = 0;
		end
		if (out_fire)
			out_gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (long_hold > 0) begin
			long_hold--;
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	// monitor
	always @(posedge clk) begin
		host_stats_t got, want;
		out_fire <= out_valid && out_ready;
		if (out_valid && out_ready) begin
			got = '{status, hit_count, host_connects, host_fails, host_latency_sum,
				host_latency_count, latency_taken};
			if (stats_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: status %0d hits %0d", status, hit_count);
			end else begin
				want = stats_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp st %0d hit %0d c %0d f %0d s %0d n %0d t %0b",
							" / got st %0d hit %0d c %0d f %0d s %0d n %0d t %0b"},
							want.status, want.hits, want.connects, want.fails,
							want.lat_sum, want.lat_cnt, want.taken,
							got.status, got.hits, got.connects, got.fails,
							got.lat_sum, got.lat_cnt, got.taken);
				end
			end
		end
	end

	function automatic conn_evt_t mk_evt(op_t op, logic [63:0] tid, logic [63:0] t,
			logic [47:0] key);
		conn_evt_t e;
		e.op = op;
		e.tid = tid;
		e.now = t;
		e.readable = 1'b1;
		e.alen = 8'd16;
		e.fam = FAMILY_IPV4;
		e.daddr = key[47:16];
		e.dport = key[15:0];
		e.failed = 1'b0;
		return e;
	endfunction

	function automatic conn_evt_t noise_evt();
		conn_evt_t e;
		e.op = op_t'($urandom_range(0, 3));
		e.tid = {$urandom, $urandom};
		e.now = {$urandom, $urandom};
		e.readable = 1'($urandom_range(0, 1));
		e.alen = 8'($urandom);
		e.fam = 16'($urandom);
		e.daddr = $urandom;
		e.dport = 16'($urandom);
		e.failed = 1'($urandom_range(0, 1));
		return e;
	endfunction

	function automatic conn_evt_t rand_evt();
		conn_evt_t e;
		int unsigned pick, v;
		pick = $urandom_range(0, 99);
		sim_clock += 64'($urandom_range(1, 5000));
		if (pick < 38) begin
			e = mk_evt(OP_START, tid_pool[$urandom_range(0, TID_POOL - 1)], sim_clock,
				key_pool[$urandom_range(0, KEY_POOL - 1)]);
			e.alen = 8'($urandom_range(8, 255));
		end else if (pick < 76) begin
			e = mk_evt(OP_FINISH, tid_pool[$urandom_range(0, TID_POOL - 1)], sim_clock, '0);
			v = $urandom_range(0, 9);
			if (v == 0)
				e.now = {$urandom, $urandom};
			else if (v == 1)
				e.now = sim_clock - 64'($urandom_range(0, 20000));
			e.failed = 1'($urandom_range(0, 1));
		end else if (pick < 88) begin
			e = mk_evt(OP_QUERY, '0, sim_clock, key_pool[$urandom_range(0, KEY_POOL - 1)]);
			if ($urandom_range(0, 4) == 0)
				e = noise_evt();
			e.op = OP_QUERY;
		end else
			e = noise_evt();
		return e;
	endfunction

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (evt_queue.size() != 0 || in_valid || stats_due.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_limit(logic [39:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= {24'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		limit_ns = val;
	endtask

	initial begin
		conn_evt_t e;
		logic [47:0] k1, k2;
		logic [63:0] ta, tmax;
		logic [39:0] limits[5];
		k1 = 48'hFFFF_FFFF_FFFF;
		k2 = 48'h0A00_0001_0050;
		ta = 64'h0000_1234_0000_0001;
		tmax = '1;
		tid_pool[0] = '0;
		tid_pool[1] = '1;
		for (int i = 2; i < TID_POOL; i++)
			tid_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = k1;
		key_pool[2] = k2;
		for (int i = 3; i < KEY_POOL; i++)
			key_pool[i] = {$urandom, 16'($urandom)};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_limit(LIMIT_RESET);

		// directed
		evt_queue.push_back(mk_evt(OP_QUERY, '0, '0, k1));
		evt_queue.push_back(mk_evt(OP_NONE, tmax, tmax, k1));
		evt_queue.push_back(mk_evt(OP_FINISH, '0, 64'd50, '0));
		e = mk_evt(OP_START, ta, 64'd60, k1); e.readable = 1'b0; evt_queue.push_back(e);
		e = mk_evt(OP_START, ta, 64'd60, k1); e.alen = 8'd7; evt_queue.push_back(e);
		e = mk_evt(OP_START, ta, 64'd60, k1); e.fam = 16'd10; evt_queue.push_back(e);
		e = mk_evt(OP_START, ta, 64'd100, k1); e.alen = 8'd255; evt_queue.push_back(e);
		e = mk_evt(OP_FINISH, ta, 64'd100, '0); e.failed = 1'b1; evt_queue.push_back(e);
		evt_queue.push_back(mk_evt(OP_START, ta, 64'd1000, k1));
		evt_queue.push_back(mk_evt(OP_FINISH, ta, 64'd999 + LIMIT_RESET, '0));
		evt_queue.push_back(mk_evt(OP_START, ta, 64'd1000, k1));
		evt_queue.push_back(mk_evt(OP_FINISH, ta, 64'd1000 + LIMIT_RESET, '0));
		evt_queue.push_back(mk_evt(OP_START, tmax, tmax - 64'd5, k2));
		evt_queue.push_back(mk_evt(OP_FINISH, tmax, 64'd5, '0));
		evt_queue.push_back(mk_evt(OP_START, '0, 64'd10, k1));
		evt_queue.push_back(mk_evt(OP_START, '0, 64'd20, k2));
		evt_queue.push_back(mk_evt(OP_FINISH, '0, 64'd30, '0));
		evt_queue.push_back(mk_evt(OP_FINISH, '0, 64'd40, '0));
		evt_queue.push_back(mk_evt(OP_QUERY, '0, '0, k1));
		evt_queue.push_back(mk_evt(OP_QUERY, '0, '0, k2));
		wait_idle();

		// limit zero accepts nothing
		write_limit('0);
		evt_queue.push_back(mk_evt(OP_START, ta, 64'd100, k2));
		evt_queue.push_back(mk_evt(OP_FINISH, ta, 64'd101, '0));
		wait_idle();

		limits[0] = LIMIT_RESET;
		limits[1] = 40'd1;
		limits[2] = '1;
		limits[3] = {8'($urandom), 32'($urandom)} | 40'd1;
		limits[4] = 40'd3000;
		for (int ph = 0; ph < 5; ph++) begin
			write_limit(limits[ph]);
			for (int i = 0; i < RAND_PHASE; i++) begin
				if (i % 90 == 0)
					no_gaps = ($urandom_range(0, 2) == 0);
				if (ph == 2 && i == 100) begin
					@(posedge clk);
					long_hold_req = 400;
				end
				evt_queue.push_back(rand_evt());
				while (evt_queue.size() > 8)
					@(posedge clk);
			end
			wait_idle();
		end
		no_gaps = 1'b0;

		for (int i = 0; i < KEY_POOL; i++)
			evt_queue.push_back(mk_evt(OP_QUERY, '0, '0, key_pool[i]));
		wait_idle();
		repeat (50) @(posedge clk);

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
